FILE: src/aclp_pkg.sv
package aclp_pkg;

  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_J     = 8'h6A;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_NUL   = 8'h00;

  localparam int unsigned MAG_W = 17;
  localparam logic [MAG_W-1:0] ACC_MAX = 17'h1FFFF;
  localparam logic [2:0] TOK_CAP = 3'd4;

  typedef struct packed {
    logic [MAG_W-1:0] mag;
    logic             neg;
    logic             started;
    logic             stopped;
  } num_t;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_POT    = 2'd1,
    EV_TOGGLE = 2'd2,
    EV_PRESS  = 2'd3
  } event_kind_t;

  typedef enum logic [2:0] {
    ERR_OK    = 3'd0,
    ERR_EMPTY = 3'd1,
    ERR_TYPE  = 3'd2,
    ERR_COUNT = 3'd3,
    ERR_INDEX = 3'd4,
    ERR_VALUE = 3'd5
  } error_t;

  // atoi-style range check: a nonzero negative number never fits
  function automatic logic num_below(num_t n, logic [MAG_W-1:0] limit);
    num_below = !(n.neg && (n.mag != '0)) && (n.mag < limit);
  endfunction

endpackage

FILE: src/aclp_number.sv
module aclp_number
  import aclp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       clear,
  input  logic       feed,
  input  logic [7:0] char_in,
  output num_t       num
);

  num_t base;
  num_t num_next;
  logic blank;
  logic digit;
  logic [MAG_W+3:0] prod;

  assign blank = (char_in == CH_SPACE) || ((char_in >= CH_TAB) && (char_in <= CH_CR));
  assign digit = (char_in >= CH_ZERO) && (char_in <= CH_NINE);

  always_comb begin
    base = clear ? num_t'('0) : num;
    // mag * 10 + digit as two shifts and two adds
    prod = ({4'b0, base.mag} << 3) + ({4'b0, base.mag} << 1)
         + {{MAG_W{1'b0}}, 4'(char_in - CH_ZERO)};
    num_next = base;
    if (feed && !base.stopped) begin
      if (!base.started && blank) begin
        num_next = base;
      end else if (!base.started && (char_in == CH_PLUS)) begin
        num_next.started = 1'b1;
      end else if (!base.started && (char_in == CH_MINUS)) begin
        num_next.started = 1'b1;
        num_next.neg = 1'b1;
      end else begin
        num_next.started = 1'b1;
        if (digit) begin
          num_next.mag = (prod > {4'b0, ACC_MAX}) ? ACC_MAX : prod[MAG_W-1:0];
        end else begin
          num_next.stopped = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      num <= '0;
    end else begin
      num <= num_next;
    end
  end

endmodule

FILE: src/ascii_control_line_parser.sv
// Command line parser: takes one received character per cycle on the input
// channel and judges each comma-separated line (type, index, value) when its
// newline arrives, giving at most one result item per newline in the next cycle
// through an output register. The input stalls only while a finished result is
// still waiting in the output register. Runs of commas collapse, a zero byte
// ends a line's content, and a line longer than LINE_LIMIT-1 characters restarts.
// Button levels are kept between lines.
module ascii_control_line_parser
  import aclp_pkg::*;
#(
  parameter int LINE_LIMIT  = 64,
  parameter int NUM_POTS    = 4,
  parameter int NUM_BUTTONS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  event_kind,
  output logic [3:0]  target_index,
  output logic [15:0] target_value,
  output logic [2:0]  error_code
);

  localparam int CW = $clog2(LINE_LIMIT);
  localparam int BW = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
  localparam logic [CW-1:0] CNT_RESTART = CW'(LINE_LIMIT - 1);
  localparam logic [CW-1:0] CNT_CONTENT = CW'(LINE_LIMIT - 2);
  localparam logic [MAG_W-1:0] POT_LIMIT = MAG_W'(NUM_POTS);
  localparam logic [MAG_W-1:0] BTN_LIMIT = MAG_W'(NUM_BUTTONS);
  localparam logic [MAG_W-1:0] RAW_LIMIT = 17'h10000;
  localparam logic [MAG_W-1:0] LVL_LIMIT = 17'd2;

  logic [CW-1:0] char_count, char_count_next;
  logic [2:0]    token_count, token_count_next;
  logic          inside_token, inside_token_next;
  logic          line_ended_early, line_ended_early_next;
  logic [7:0]    type_char, type_char_next;
  logic          msg_pending, msg_pending_next;
  logic [NUM_BUTTONS-1:0] button_level;

  logic accept;
  logic is_nl;
  logic restart;
  logic [CW-1:0] pos;
  logic [2:0] tok_base;
  logic [2:0] tok_sel;
  logic in_base;
  logic early_base;
  logic num_clear;
  logic idx_feed;
  logic val_feed;
  logic emit;
  num_t idx_num;
  num_t val_num;

  event_kind_t j_event;
  error_t      j_error;
  logic [3:0]  j_index;
  logic [15:0] j_value;
  logic        j_btn_we;
  logic        j_level;
  logic [BW-1:0] j_bidx;

  assign in_ready = !out_valid || out_ready;
  assign accept = in_valid && in_ready;
  assign is_nl = (rx_byte == CH_NL);

  aclp_number u_index (
    .clk     (clk),
    .rst     (rst),
    .clear   (num_clear),
    .feed    (idx_feed),
    .char_in (rx_byte),
    .num     (idx_num)
  );

  aclp_number u_value (
    .clk     (clk),
    .rst     (rst),
    .clear   (num_clear),
    .feed    (val_feed),
    .char_in (rx_byte),
    .num     (val_num)
  );

  // judgement of the line held so far, used on newline
  always_comb begin
    j_event = EV_NONE;
    j_error = ERR_OK;
    j_index = '0;
    j_value = '0;
    j_btn_we = 1'b0;
    j_level = (val_num.mag == '0);
    j_bidx = idx_num.mag[BW-1:0];
    if (token_count == '0) begin
      j_error = ERR_EMPTY;
    end else if ((type_char != CH_J) && (type_char != CH_B)) begin
      j_error = ERR_TYPE;
    end else if (token_count != 3'd3) begin
      j_error = ERR_COUNT;
    end else if (type_char == CH_J) begin
      if (!num_below(idx_num, POT_LIMIT)) begin
        j_error = ERR_INDEX;
      end else if (!num_below(val_num, RAW_LIMIT)) begin
        j_error = ERR_VALUE;
      end else begin
        j_event = EV_POT;
        j_index = idx_num.mag[3:0];
        j_value = val_num.mag[15:0];
      end
    end else begin
      if (!num_below(idx_num, BTN_LIMIT)) begin
        j_error = ERR_INDEX;
      end else if (!num_below(val_num, LVL_LIMIT)) begin
        j_error = ERR_VALUE;
      end else begin
        j_btn_we = 1'b1;
        j_index = idx_num.mag[3:0];
        j_value = {15'b0, j_level};
        if (idx_num.mag == '0) begin
          j_event = EV_TOGGLE;
        end else if (j_level && !button_level[j_bidx]) begin
          j_event = EV_PRESS;
        end
      end
    end
  end

  always_comb begin
    char_count_next = char_count;
    token_count_next = token_count;
    inside_token_next = inside_token;
    line_ended_early_next = line_ended_early;
    type_char_next = type_char;
    msg_pending_next = msg_pending;
    restart = (char_count >= CNT_RESTART);
    pos = restart ? '0 : char_count;
    tok_base = restart ? '0 : token_count;
    in_base = restart ? 1'b0 : inside_token;
    early_base = restart ? 1'b0 : line_ended_early;
    tok_sel = tok_base;
    num_clear = 1'b0;
    idx_feed = 1'b0;
    val_feed = 1'b0;
    emit = 1'b0;
    if (accept) begin
      if (is_nl) begin
        msg_pending_next = msg_pending || (token_count != '0);
        emit = msg_pending_next;
        char_count_next = '0;
        token_count_next = '0;
        inside_token_next = 1'b0;
        line_ended_early_next = 1'b0;
        type_char_next = '0;
        num_clear = 1'b1;
      end else begin
        msg_pending_next = 1'b0;
        num_clear = restart;
        char_count_next = pos + 1'b1;
        token_count_next = tok_base;
        inside_token_next = in_base;
        line_ended_early_next = early_base;
        if (restart) begin
          type_char_next = '0;
        end
        if ((pos < CNT_CONTENT) && !early_base) begin
          if (rx_byte == CH_NUL) begin
            line_ended_early_next = 1'b1;
          end else if (rx_byte == CH_COMMA) begin
            inside_token_next = 1'b0;
          end else begin
            if (!in_base) begin
              inside_token_next = 1'b1;
              if (tok_base < TOK_CAP) begin
                tok_sel = tok_base + 1'b1;
              end
            end
            token_count_next = tok_sel;
            if (tok_sel == 3'd1) begin
              type_char_next = rx_byte;
            end
            idx_feed = (tok_sel == 3'd2);
            val_feed = (tok_sel == 3'd3);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      char_count <= '0;
      token_count <= '0;
      inside_token <= 1'b0;
      line_ended_early <= 1'b0;
      type_char <= '0;
      msg_pending <= 1'b0;
      button_level <= '0;
      out_valid <= 1'b0;
    end else begin
      char_count <= char_count_next;
      token_count <= token_count_next;
      inside_token <= inside_token_next;
      line_ended_early <= line_ended_early_next;
      type_char <= type_char_next;
      msg_pending <= msg_pending_next;
      if (emit && j_btn_we) begin
        button_level[j_bidx] <= j_level;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result register, payload needs no reset
  always_ff @(posedge clk) begin
    if (emit) begin
      event_kind <= j_event;
      target_index <= j_index;
      target_value <= j_value;
      error_code <= j_error;
    end
  end

`ifndef NO_ASSERTIONS
  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && (error_code != ERR_OK) |->
      (event_kind == EV_NONE) && (target_index == '0) && (target_value == '0))
    else $error("error item carries a payload");

  a_press_level: assert property (@(posedge clk) disable iff (rst)
    out_valid && (event_kind == EV_PRESS) |->
      (target_value == 16'd1) && (target_index != '0))
    else $error("press item without pressed level");

  a_byte_clears_pending: assert property (@(posedge clk) disable iff (rst)
    accept && !is_nl |=> !msg_pending)
    else $error("pending flag survived an ordinary byte");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    (char_count <= CNT_RESTART) && (token_count <= TOK_CAP))
    else $error("line counters out of range");

  a_result_on_newline: assert property (@(posedge clk) disable iff (rst)
    out_valid && !$past(out_valid) |-> $past(accept && is_nl))
    else $error("result item without a newline");
`endif

endmodule
